// ===== rtl/core/nts_pkg.sv =====
// package for the nearest timestamp search block
// holds widths, action and status codes, the sequencer state type and the distance helper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nts_pkg;

    localparam int NTS_TABLE_DEPTH = 1024;
    localparam int NTS_TIME_W      = 62;
    localparam int NTS_TOL_W       = 63;
    localparam int NTS_SLOT_W      = 10;
    localparam int NTS_ACT_W       = 2;
    localparam int NTS_STAT_W      = 2;
    localparam int NTS_IN_DATA_W   = 64;
    localparam int NTS_OUT_DATA_W  = NTS_SLOT_W + NTS_TIME_W;

    typedef logic [NTS_TIME_W-1:0] t_time;

    localparam logic [NTS_ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [NTS_ACT_W-1:0] ACT_CLEAR  = 2'd1;
    localparam logic [NTS_ACT_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [NTS_STAT_W-1:0] STAT_FOUND   = 2'd0;
    localparam logic [NTS_STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [NTS_STAT_W-1:0] STAT_OUTSIDE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FETCH_R,
        ST_LAST,
        ST_PICK,
        ST_CHECK,
        ST_DONE
    } t_state;

    function automatic t_time abs_diff(input t_time a, input t_time b);
        t_time d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nts_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nts_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_timestamp_search.sv =====
// nearest timestamp search: top level with table, binary search sequencer and output register
// depends on nts_pkg and nts_ram
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: action, tdata: time_value
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status, tdata: nearest_slot, nearest_time
//  cfg       in   i_cfg_wr_en                  i_cfg_wr_data: tolerance
//
// append, clear and unused codes leave the sequencer idle, so the block stays ready for the next item
// a query steps through the accept and the probes, each a registered read of the table ram,
//   then two reads of the final bounds, one pick, one tolerance compare and one output load
// an exact hit on a probe ends the query early; on an empty table a query skips to the output load
// reset (synchronous, active low) empties the table and sets tolerance to -1
// a finished result waits in the output register; a new item is taken meanwhile, and a
// later query holds in its last step until that register is free
`timescale 1ns / 1ps
`default_nettype none

module nearest_timestamp_search
    import nts_pkg::*;
#(
    parameter int TABLE_DEPTH = NTS_TABLE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_cfg_wr_en,
    input  wire logic [NTS_TOL_W-1:0]      i_cfg_wr_data,   // tolerance, signed

    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [NTS_IN_DATA_W-1:0]  s_axis_tdata,    // [61:0] time_value, [63:62] zero
    input  wire logic [NTS_ACT_W-1:0]      s_axis_tuser,    // [1:0] action

    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [NTS_OUT_DATA_W-1:0] m_axis_tdata,    // [9:0] nearest_slot, [71:10] nearest_time
    output logic      [NTS_STAT_W-1:0]     m_axis_tuser     // [1:0] status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // control registers
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [NTS_TOL_W-1:0]  r_tol;
    logic                  r_out_valid, n_out_valid;

    // payload registers
    t_time                 r_query, n_query;
    logic [IDX_W-1:0]      r_left, n_left;
    logic [IDX_W-1:0]      r_right, n_right;
    logic [IDX_W-1:0]      r_mid, n_mid;
    t_time                 r_tl, n_tl;
    t_time                 r_tr, n_tr;
    t_time                 r_dl, n_dl;
    t_time                 r_dr, n_dr;
    logic [IDX_W-1:0]      r_res_slot, n_res_slot;
    t_time                 r_res_time, n_res_time;
    t_time                 r_res_dist, n_res_dist;
    logic [NTS_STAT_W-1:0] r_res_stat, n_res_stat;
    logic [NTS_SLOT_W-1:0] r_out_slot, n_out_slot;
    t_time                 r_out_time, n_out_time;
    logic [NTS_STAT_W-1:0] r_out_stat, n_out_stat;

    logic                  w_in_xfer;
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_rd_addr;
    t_time                 w_rd_data;
    t_time                 w_dist;
    logic [CNT_W-1:0]      w_last;
    logic [IDX_W:0]        w_sum;
    logic                  w_gt;
    logic                  w_lt;
    logic                  w_load;

    nts_ram #(
        .WIDTH (NTS_TIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (s_axis_tdata[NTS_TIME_W-1:0]),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_wr_en       = w_in_xfer && (s_axis_tuser == ACT_APPEND)
                           && (r_count < CNT_W'(TABLE_DEPTH));

    // shared distance and compare unit: table word against the query time
    assign w_dist = abs_diff(w_rd_data, r_query);
    assign w_gt   = (w_rd_data > r_query);
    assign w_lt   = (w_rd_data < r_query);
    assign w_last = r_count - CNT_W'(1);
    assign w_load = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_query     = r_query;
        n_left      = r_left;
        n_right     = r_right;
        n_mid       = r_mid;
        n_tl        = r_tl;
        n_tr        = r_tr;
        n_dl        = r_dl;
        n_dr        = r_dr;
        n_res_slot  = r_res_slot;
        n_res_time  = r_res_time;
        n_res_dist  = r_res_dist;
        n_res_stat  = r_res_stat;
        n_out_slot  = r_out_slot;
        n_out_time  = r_out_time;
        n_out_stat  = r_out_stat;
        w_rd_addr   = r_mid;
        w_sum       = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_query = s_axis_tdata[NTS_TIME_W-1:0];
                    case (s_axis_tuser)
                        ACT_APPEND: begin
                            if (w_wr_en) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_QUERY: begin
                            n_left = '0;
                            n_right = w_last[IDX_W-1:0];
                            if (r_count == '0) begin
                                n_res_slot = '0;
                                n_res_time = '0;
                                n_res_stat = STAT_EMPTY;
                                n_state    = ST_DONE;
                            end else if (r_count == CNT_W'(1)) begin
                                w_rd_addr = '0;
                                n_state   = ST_FETCH_R;
                            end else begin
                                w_sum     = {1'b0, w_last[IDX_W-1:0]};
                                n_mid     = w_sum[IDX_W:1];
                                w_rd_addr = n_mid;
                                n_state   = ST_PROBE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (!w_gt && !w_lt) begin
                    // exact hit ends the search at once
                    n_res_slot = r_mid;
                    n_res_time = w_rd_data;
                    n_res_stat = STAT_FOUND;
                    n_state    = ST_DONE;
                end else begin
                    n_left  = w_lt ? r_mid : r_left;
                    n_right = w_gt ? r_mid : r_right;
                    w_sum   = {1'b0, n_left} + {1'b0, n_right};
                    // bounds adjacent, or collapsed onto one slot on a two entry table
                    if ({1'b0, n_left} + (IDX_W+1)'(1) >= {1'b0, n_right}) begin
                        w_rd_addr = n_left;
                        n_state   = ST_FETCH_R;
                    end else begin
                        n_mid     = w_sum[IDX_W:1];
                        w_rd_addr = n_mid;
                    end
                end
            end
            ST_FETCH_R: begin
                // left bound word arrives, right bound read goes out
                n_tl      = w_rd_data;
                n_dl      = w_dist;
                w_rd_addr = r_right;
                n_state   = ST_LAST;
            end
            ST_LAST: begin
                n_tr    = w_rd_data;
                n_dr    = w_dist;
                n_state = ST_PICK;
            end
            ST_PICK: begin
                // equal distance keeps the lower slot
                if (r_dl > r_dr) begin
                    n_res_slot = r_right;
                    n_res_time = r_tr;
                    n_res_dist = r_dr;
                end else begin
                    n_res_slot = r_left;
                    n_res_time = r_tl;
                    n_res_dist = r_dl;
                end
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!r_tol[NTS_TOL_W-1] && (r_res_dist > r_tol[NTS_TIME_W-1:0])) begin
                    n_res_stat = STAT_OUTSIDE;
                end else begin
                    n_res_stat = STAT_FOUND;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = NTS_SLOT_W'(r_res_slot);
                    n_out_time  = r_res_time;
                    n_out_stat  = r_res_stat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_tol       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_query    <= n_query;
        r_left     <= n_left;
        r_right    <= n_right;
        r_mid      <= n_mid;
        r_tl       <= n_tl;
        r_tr       <= n_tr;
        r_dl       <= n_dl;
        r_dr       <= n_dr;
        r_res_slot <= n_res_slot;
        r_res_time <= n_res_time;
        r_res_dist <= n_res_dist;
        r_res_stat <= n_res_stat;
        r_out_slot <= n_out_slot;
        r_out_time <= n_out_time;
        r_out_stat <= n_out_stat;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_time, r_out_slot};
    assign m_axis_tuser  = r_out_stat;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_left <= r_mid) && (r_mid < r_right))
        else $error("probe slot outside search window");

    a_bounds_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH_R) |-> ({1'b0, r_right} < (IDX_W+1)'(r_count)))
        else $error("final bound beyond filled entries");

    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> (r_count == $past(r_count)))
        else $error("entry count changed during a query");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_stat == STAT_EMPTY)) |-> (m_axis_tdata == '0))
        else $error("empty result carries nonzero slot or time");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for nearest_timestamp_search: append, clear, query, unused items on the stream
// ports, with a scoreboard that predicts every query answer; depends on nts_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import nts_pkg::*;

    localparam logic [NTS_ACT_W-1:0] ACT_UNUSED   = 2'd3;
    localparam logic [NTS_TOL_W-1:0] TOL_OFF      = '1;
    localparam logic [NTS_TOL_W-1:0] TOL_MAX      = {1'b0, {NTS_TIME_W{1'b1}}};
    localparam logic [NTS_TOL_W-1:0] TOL_MOST_NEG = {1'b1, {NTS_TIME_W{1'b0}}};
    localparam t_time TIME_MAX      = '1;
    localparam int    SETTLE_CYCLES = 40;
    localparam int    REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [NTS_STAT_W-1:0] status;
        logic [NTS_SLOT_W-1:0] slot;
        t_time                 tm;
    } t_answer;

    class nearest_scoreboard;
        t_time                stamps [NTS_TABLE_DEPTH];
        int unsigned          n_stamps;
        logic [NTS_TOL_W-1:0] tolerance;
        t_answer              awaited [$];
        int unsigned          n_bad;

        function new();
            n_stamps  = 0;
            tolerance = TOL_OFF;
            n_bad     = 0;
        endfunction

        function void note_item(input logic [NTS_ACT_W-1:0] act, input t_time tv);
            t_answer     ans;
            int unsigned lo, hi, mid, pick;
            bit          done, hit;
            t_time       d_lo, d_hi, d_pick;
            case (act)
                ACT_APPEND: begin
                    if (n_stamps < NTS_TABLE_DEPTH) begin
                        stamps[n_stamps] = tv;
                        n_stamps++;
                    end
                end
                ACT_CLEAR: begin
                    n_stamps = 0;
                end
                ACT_QUERY: begin
                    ans.status = STAT_EMPTY;
                    ans.slot   = '0;
                    ans.tm     = '0;
                    if (n_stamps != 0) begin
                        lo   = 0;
                        hi   = n_stamps - 1;
                        hit  = 1'b0;
                        pick = 0;
                        done = (lo >= hi);
                        while (!done) begin
                            mid = (lo + hi) / 2;
                            if (stamps[mid] > tv) begin
                                hi = mid;
                            end else if (stamps[mid] < tv) begin
                                lo = mid;
                            end else begin
                                hit  = 1'b1;
                                pick = mid;
                                done = 1'b1;
                            end
                            // on a two entry table the bounds can collapse onto one slot
                            if (lo + 1 == hi || lo >= hi) begin
                                done = 1'b1;
                            end
                        end
                        ans.status = STAT_FOUND;
                        if (!hit) begin
                            d_lo   = (stamps[lo] >= tv) ? stamps[lo] - tv : tv - stamps[lo];
                            d_hi   = (stamps[hi] >= tv) ? stamps[hi] - tv : tv - stamps[hi];
                            pick   = (d_lo > d_hi) ? hi : lo;
                            d_pick = (d_lo > d_hi) ? d_hi : d_lo;
                            if (!tolerance[NTS_TOL_W-1] && {1'b0, d_pick} > tolerance) begin
                                ans.status = STAT_OUTSIDE;
                            end
                        end
                        ans.slot = pick[NTS_SLOT_W-1:0];
                        ans.tm   = stamps[pick];
                    end
                    awaited.insert(awaited.size(), ans);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_answer(input t_answer got);
            t_answer want;
            if (awaited.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_LIMIT) begin
                    $display("unexpected result: status %0d slot %0d time %0h",
                             got.status, got.slot, got.tm);
                end
            end else begin
                want = awaited.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                        got.tm !== want.tm) begin
                    n_bad++;
                    if (n_bad <= REPORT_LIMIT) begin
                        $display("mismatch at %0t: status %0d/%0d slot %0d/%0d time %0h/%0h",
                                 $realtime, want.status, got.status, want.slot, got.slot,
                                 want.tm, got.tm);
                    end
                end
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [NTS_TOL_W-1:0]      i_cfg_wr_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [NTS_IN_DATA_W-1:0]  s_axis_tdata;    // [61:0] time_value, [63:62] zero
    logic [NTS_ACT_W-1:0]      s_axis_tuser;    // [1:0] action
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [NTS_OUT_DATA_W-1:0] m_axis_tdata;    // [9:0] nearest_slot, [71:10] nearest_time
    logic [NTS_STAT_W-1:0]     m_axis_tuser;    // [1:0] status

    nearest_scoreboard sb;
    bit                bursts_on;

    nearest_timestamp_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** nearest_timestamp_search: FAILED **");
        $finish;
    end

    // result side: random stall bursts, always ready once bursts are off
    initial begin
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                m_axis_tready = 1'b0;
            end else if (bursts_on && $urandom_range(0, 4) == 0) begin
                stall         = $urandom_range(1, 6) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.slot   = m_axis_tdata[NTS_SLOT_W-1:0];
            got.tm     = m_axis_tdata[NTS_OUT_DATA_W-1:NTS_SLOT_W];
            sb.check_answer(got);
        end
    end

    function automatic t_time rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[NTS_TIME_W-1:0];
    endfunction

    function automatic t_time rand_below(input t_time lim);
        if (lim == TIME_MAX) begin
            return rand_time();
        end
        return rand_time() % (lim + 1'b1);
    endfunction

    // query times that land on, next to and between stored stamps, or random, zero or the top
    function automatic t_time pick_query();
        int unsigned k, i;
        t_time       a, b, near_off;
        k = $urandom_range(0, 9);
        if (sb.n_stamps == 0 || k == 0) begin
            return rand_time();
        end
        i        = $urandom_range(0, sb.n_stamps - 1);
        a        = sb.stamps[i];
        b        = (i + 1 < sb.n_stamps) ? sb.stamps[i + 1] : a;
        near_off = t_time'($urandom_range(1, 8));
        case (k)
            1, 2: return a;
            3: return (a >= near_off) ? a - near_off : a;
            4: return (a <= TIME_MAX - near_off) ? a + near_off : a;
            5: return (b >= a) ? a + (b - a) / 2 : a;
            6: return (b >= a) ? a + (b - a + 1'b1) / 2 : b;
            7: return '0;
            8: return TIME_MAX;
            default: return a ^ (rand_time() >> $urandom_range(0, 61));
        endcase
    endfunction

    task automatic send_item(input logic [NTS_ACT_W-1:0] act, input t_time tv);
        int gap;
        @(negedge i_clk);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            gap           = $urandom_range(1, 6);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {2'b00, rand_time()};
            s_axis_tuser  = NTS_ACT_W'($urandom_range(0, 3));
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, tv};
        s_axis_tuser  = act;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(act, tv);
    endtask

    // wait until every query is answered and the block has gone quiet
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [NTS_TOL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(posedge i_clk);
        sb.tolerance = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // mostly clear, ascending appends, then queries; a little out-of-order and unused noise
    task automatic run_traffic(input int n_items, input bit full_table);
        int    sent, n_app, n_q, i;
        t_time base, lim, cur;
        sent = 0;
        while (sent < n_items) begin
            if (full_table || $urandom_range(0, 7) != 0) begin
                send_item(ACT_CLEAR, rand_time());
                sent++;
            end
            if (full_table) begin
                n_app = NTS_TABLE_DEPTH + 6;
            end else if ($urandom_range(0, 7) == 0) begin
                n_app = $urandom_range(25, 200);
            end else begin
                n_app = $urandom_range(0, 24);
            end
            base = rand_time() >> $urandom_range(0, 61);
            lim  = (TIME_MAX - base) / t_time'(n_app + 1);
            if ($urandom_range(0, 2) == 0 && lim > 8) begin
                lim = t_time'(8);
            end
            cur = base;
            for (i = 0; i < n_app; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(ACT_APPEND, rand_time());
                end else begin
                    send_item(ACT_APPEND, cur);
                    cur = cur + rand_below(lim);
                end
                if (i < NTS_TABLE_DEPTH) begin
                    sent++;
                end
                if ($urandom_range(0, 29) == 0) begin
                    send_item(ACT_UNUSED, rand_time());
                end
            end
            n_q = full_table ? 60 : $urandom_range(1, 12);
            for (i = 0; i < n_q; i++) begin
                send_item(ACT_QUERY, pick_query());
                sent++;
            end
        end
    endtask

    initial begin
        sb            = new();
        bursts_on     = 1'b1;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_APPEND;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // tolerance check is off after reset
        send_item(ACT_QUERY, TIME_MAX);
        send_item(ACT_UNUSED, TIME_MAX);
        send_item(ACT_APPEND, '0);
        send_item(ACT_QUERY, '0);
        send_item(ACT_QUERY, TIME_MAX);
        send_item(ACT_APPEND, 62'd100);
        send_item(ACT_APPEND, 62'd200);
        send_item(ACT_APPEND, 62'd300);
        send_item(ACT_APPEND, TIME_MAX);
        send_item(ACT_QUERY, 62'd150);      // equal distance, lower slot wins
        send_item(ACT_QUERY, 62'd200);
        send_item(ACT_QUERY, TIME_MAX);
        send_item(ACT_QUERY, 62'd251);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_QUERY, 62'd5);
        send_item(ACT_APPEND, 62'd50);
        send_item(ACT_APPEND, 62'd10);      // descending table
        send_item(ACT_QUERY, 62'd20);
        quiesce();
        write_tolerance('0);
        send_item(ACT_QUERY, 62'd50);
        send_item(ACT_QUERY, 62'd30);
        send_item(ACT_QUERY, '0);
        quiesce();
        write_tolerance(TOL_MAX);
        send_item(ACT_QUERY, TIME_MAX);
        send_item(ACT_APPEND, TIME_MAX);
        send_item(ACT_QUERY, 62'd1);

        quiesce();
        write_tolerance('0);
        run_traffic(40, 1'b0);
        quiesce();
        write_tolerance(TOL_MAX);
        run_traffic(40, 1'b0);
        quiesce();
        write_tolerance({1'b0, rand_time() >> $urandom_range(0, 61)});
        run_traffic(40, 1'b0);
        quiesce();
        write_tolerance(NTS_TOL_W'($urandom_range(1, 16)));
        run_traffic(1, 1'b1);
        quiesce();
        write_tolerance(TOL_MOST_NEG);
        run_traffic(40, 1'b0);
        quiesce();
        write_tolerance({1'b1, rand_time()});
        run_traffic(40, 1'b0);
        quiesce();
        write_tolerance({1'b0, rand_time()});
        run_traffic(40, 1'b0);
        quiesce();
        write_tolerance(TOL_OFF);
        bursts_on = 1'b0;
        run_traffic(40, 1'b0);
        quiesce();

        if (sb.n_bad == 0 && sb.awaited.size() == 0) begin
            $display("** nearest_timestamp_search: PASSED **");
        end else begin
            $display("** nearest_timestamp_search: FAILED **");
        end
        $finish;
    end

endmodule
